// ----- design/rgb_convolution_3x3_unit_assert.svh -----
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_UNIT_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_UNIT_ASSERT_SVH

// same-cycle implication
`define RGBCONV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication that starts in the next cycle
`define RGBCONV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rgbconv_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB 3x3 convolution package
// Sizes, register codes, payload and pipeline types shared by the block.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int COEF_FRAC_BITS = 4;
  localparam int COL_W          = $clog2(MAX_WIDTH);
  localparam int ROW_W          = 16;
  localparam int POSX_W         = 11;
  localparam int CH_W           = 8;
  localparam int PIX_W          = 3 * CH_W;
  localparam int WREG_W         = 12;
  localparam int HREG_W         = 16;
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 3;

  // products, row sums and window sums
  localparam int PROD_W = 17;
  localparam int RSUM_W = 19;
  localparam int SUM_W  = 21;

  // result queue
  localparam int QDEPTH  = 8;
  localparam int QADDR_W = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KROW_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  localparam logic [CFG_W-1:0]  RST_KROW_TOP = 24'h000000;
  localparam logic [CFG_W-1:0]  RST_KROW_MID = 24'h001000;
  localparam logic [CFG_W-1:0]  RST_KROW_BOT = 24'h000000;
  localparam logic [WREG_W-1:0] RST_WIDTH    = 12'd640;
  localparam logic [HREG_W-1:0] RST_HEIGHT   = 16'd480;

  typedef struct packed {
    logic            frame_start;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [POSX_W-1:0] pos_x;
    logic [ROW_W-1:0]  pos_y;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic              run_last;
    logic              frame_done;
  } out_t;

  // per-pixel control carried down the pipeline
  typedef struct packed {
    logic             has_filt;
    logic             has_pass;
    logic             fdone;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [PIX_W-1:0] pix;
  } ctl_t;

  // one queue entry holds all results of one input pixel
  typedef struct packed {
    logic has_filt;
    logic has_pass;
    out_t filt;
    out_t pass;
  } qent_t;

endpackage

// ----- design/rgbconv_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module rgbconv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/rgbconv_filter.sv -----
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: window and filter pipeline
// Holds the 3x3 window and forms the clamped kernel sum per channel over
// three registered stages: window, products, row sums; then sum and clamp.
// ----------------------------------------------------------------------------
module rgbconv_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            shift_en,
  input  rgbconv_pkg::ctl_t               ctl_in,
  input  logic [rgbconv_pkg::PIX_W-1:0]   col_top,
  input  logic [rgbconv_pkg::PIX_W-1:0]   col_mid,
  input  logic [rgbconv_pkg::PIX_W-1:0]   col_bot,
  input  logic [rgbconv_pkg::CFG_W-1:0]   krow_top,
  input  logic [rgbconv_pkg::CFG_W-1:0]   krow_mid,
  input  logic [rgbconv_pkg::CFG_W-1:0]   krow_bot,
  output logic                            push,
  output rgbconv_pkg::qent_t              push_data,
  output logic [1:0]                      busy_cnt
);
  import rgbconv_pkg::*;

  localparam logic signed [SUM_W-1:0] PIX_MAX = SUM_W'(255);

  logic [PIX_W-1:0] win_r [9];
  logic [CFG_W-1:0] krow [3];

  logic                     s2_v_r, s3_v_r, s4_v_r;
  ctl_t                     s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic signed [PROD_W-1:0] prod_nxt [3][9];
  logic signed [PROD_W-1:0] prod_r   [3][9];
  logic signed [RSUM_W-1:0] rsum_nxt [3][3];
  logic signed [RSUM_W-1:0] rsum_r   [3][3];
  logic signed [SUM_W-1:0]  tot      [3];
  logic signed [SUM_W-1:0]  shv      [3];
  logic [CH_W-1:0]          res      [3];

  assign krow[0] = krow_top;
  assign krow[1] = krow_mid;
  assign krow[2] = krow_bot;

  // shift the window one column left, new column enters on the right
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= col_top;
      win_r[5] <= col_mid;
      win_r[8] <= col_bot;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_nxt[ch][r*3+c] = $signed({1'b0, win_r[r*3+c][CH_W*ch +: CH_W]})
                              * $signed(krow[r][CH_W*c +: CH_W]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_nxt[ch][r] = RSUM_W'(prod_r[ch][r*3]) + RSUM_W'(prod_r[ch][r*3+1])
                        + RSUM_W'(prod_r[ch][r*3+2]);
      end
    end
  end

  // total, drop fraction, clamp to 0..255
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = SUM_W'(rsum_r[ch][0]) + SUM_W'(rsum_r[ch][1]) + SUM_W'(rsum_r[ch][2]);
      shv[ch] = tot[ch] >>> COEF_FRAC_BITS;
      if (tot[ch] < 0) begin
        res[ch] = '0;
      end else if (shv[ch] > PIX_MAX) begin
        res[ch] = '1;
      end else begin
        res[ch] = shv[ch][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    rsum_r   <= rsum_nxt;
    s2_ctl_r <= ctl_in;
    s3_ctl_r <= s2_ctl_r;
    s4_ctl_r <= s3_ctl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= shift_en;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_comb begin
    push_data.has_filt       = s4_ctl_r.has_filt;
    push_data.has_pass       = s4_ctl_r.has_pass;
    push_data.filt.pos_x     = POSX_W'(s4_ctl_r.x - COL_W'(1));
    push_data.filt.pos_y     = s4_ctl_r.y - ROW_W'(1);
    push_data.filt.red_out   = res[0];
    push_data.filt.green_out = res[1];
    push_data.filt.blue_out  = res[2];
    push_data.filt.run_last  = !s4_ctl_r.has_pass;
    push_data.filt.frame_done = !s4_ctl_r.has_pass && s4_ctl_r.fdone;
    push_data.pass.pos_x     = POSX_W'(s4_ctl_r.x);
    push_data.pass.pos_y     = s4_ctl_r.y;
    push_data.pass.red_out   = s4_ctl_r.pix[CH_W-1:0];
    push_data.pass.green_out = s4_ctl_r.pix[2*CH_W-1:CH_W];
    push_data.pass.blue_out  = s4_ctl_r.pix[3*CH_W-1:2*CH_W];
    push_data.pass.run_last  = 1'b1;
    push_data.pass.frame_done = s4_ctl_r.fdone;
  end

  assign push     = s4_v_r && (s4_ctl_r.has_filt || s4_ctl_r.has_pass);
  assign busy_cnt = 2'(s2_v_r) + 2'(s3_v_r) + 2'(s4_v_r);

endmodule

// ----- design/rgbconv_outq.sv -----
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: result queue
// Stores one entry per pixel with up to two results and hands them out one
// transfer at a time, filtered result first.
// ----------------------------------------------------------------------------
module rgbconv_outq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  rgbconv_pkg::qent_t               push_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rgbconv_pkg::out_t                out_data,
  output logic [rgbconv_pkg::QCNT_W-1:0]   count
);
  import rgbconv_pkg::*;

  qent_t              mem_r [QDEPTH];
  logic [QADDR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               sub_r;
  qent_t              cur;
  logic               two, xfer, pop;

  assign cur       = mem_r[rd_ptr_r];
  assign two       = cur.has_filt && cur.has_pass;
  assign out_valid = (count_r != '0);
  assign out_data  = (cur.has_filt && !sub_r) ? cur.filt : cur.pass;
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && (!two || sub_r);
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QADDR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QADDR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QADDR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QADDR_W'(1);
        sub_r    <= 1'b0;
      end else if (xfer) begin
        sub_r <= 1'b1;
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ----- design/rgb_convolution_3x3_unit.sv -----
// Path: a transferred pixel goes through the input register, window, products,
//   row sums and clamp into the queue before its results show on out_valid.
// Throughput: one pixel per cycle while in_ready is high; a pixel in the last
//   row or last column past the first two gives two results, sent one by one.
// Reset (rst_n, synchronous): counters, valid flags, queue pointers and
//   config registers reset; the line memory and pipeline data are not cleared.
// ----------------------------------------------------------------------------
// RGB 3x3 convolution unit
// Raster-order RGB stream through two line buffers kept in one RAM, a 3x3
// window and one Q4.4 kernel shared by all channels; border pixels pass through.
// ----------------------------------------------------------------------------
`include "rgb_convolution_3x3_unit_assert.svh"

module rgb_convolution_3x3_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rgbconv_pkg::in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rgbconv_pkg::out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [rgbconv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbconv_pkg::CFG_W-1:0]      cfg_wdata
);
  import rgbconv_pkg::*;

  logic [CFG_W-1:0]  krow_top_r, krow_mid_r, krow_bot_r;
  logic [WREG_W-1:0] width_r;
  logic [HREG_W-1:0] height_r;
  logic [WREG_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;

  logic [COL_W-1:0]  col_count_r, col_nxt;
  logic [ROW_W-1:0]  row_count_r, row_nxt;
  logic [COL_W-1:0]  col0, x_new;
  logic [ROW_W-1:0]  row0, y_new;
  logic [ROW_W:0]    row1, yn;
  logic [WREG_W-1:0] xn;
  logic              last_col, last_row;
  ctl_t              ctl_new;
  logic              accept;

  logic              s1_v_r, s1_fwd_r;
  ctl_t              s1_ctl_r;
  logic [PIX_W-1:0]  fwd_a_r, fwd_b_r;
  logic [PIX_W-1:0]  above, above2;
  logic [2*PIX_W-1:0] line_q;

  logic              push;
  qent_t             push_data;
  logic [1:0]        filt_busy;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   occ;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krow_top_r <= RST_KROW_TOP;
      krow_mid_r <= RST_KROW_MID;
      krow_bot_r <= RST_KROW_BOT;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KROW_TOP: krow_top_r <= cfg_wdata;
        REG_KROW_MID: krow_mid_r <= cfg_wdata;
        REG_KROW_BOT: krow_bot_r <= cfg_wdata;
        REG_WIDTH:    width_r    <= cfg_wdata[WREG_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = WREG_W'(1);
    end else if (width_r > WREG_W'(MAX_WIDTH)) begin
      w_eff = WREG_W'(MAX_WIDTH);
    end
    h_eff = (height_r == '0) ? ROW_W'(1) : height_r;
  end

  // position of the incoming pixel, with wrap for shrunk dimensions
  always_comb begin
    col0 = in_data.frame_start ? '0 : col_count_r;
    row0 = in_data.frame_start ? '0 : row_count_r;
    if (WREG_W'(col0) >= w_eff) begin
      x_new = '0;
      row1  = {1'b0, row0} + (ROW_W+1)'(1);
    end else begin
      x_new = col0;
      row1  = {1'b0, row0};
    end
    y_new = (row1 >= {1'b0, h_eff}) ? '0 : row1[ROW_W-1:0];

    xn = WREG_W'(x_new) + WREG_W'(1);
    yn = {1'b0, y_new} + (ROW_W+1)'(1);
    if (xn >= w_eff) begin
      col_nxt = '0;
      row_nxt = (yn >= {1'b0, h_eff}) ? '0 : yn[ROW_W-1:0];
    end else begin
      col_nxt = xn[COL_W-1:0];
      row_nxt = y_new;
    end

    last_col = (WREG_W'(x_new) == w_eff - WREG_W'(1));
    last_row = (y_new == h_eff - ROW_W'(1));

    ctl_new.has_filt = (x_new >= COL_W'(2)) && (y_new >= ROW_W'(2));
    ctl_new.has_pass = (x_new == '0) || (y_new == '0) || last_col || last_row;
    ctl_new.fdone    = last_col && last_row;
    ctl_new.x        = x_new;
    ctl_new.y        = y_new;
    ctl_new.pix      = {in_data.blue_in, in_data.green_in, in_data.red_in};
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      s1_v_r      <= 1'b0;
    end else begin
      if (accept) begin
        col_count_r <= col_nxt;
        row_count_r <= row_nxt;
      end
      s1_v_r <= accept;
    end
  end

  // forward the pending write when the next pixel reads the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl_new;
      s1_fwd_r <= s1_v_r && (s1_ctl_r.x == x_new);
      fwd_a_r  <= s1_ctl_r.pix;
      fwd_b_r  <= above;
    end
  end

  assign above  = s1_fwd_r ? fwd_a_r : line_q[PIX_W-1:0];
  assign above2 = s1_fwd_r ? fwd_b_r : line_q[2*PIX_W-1:PIX_W];

  // line memory entry: {two rows above, one row above}
  rgbconv_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_ctl_r.x),
    .wdata ({above, s1_ctl_r.pix}),
    .raddr (x_new),
    .rdata (line_q)
  );

  rgbconv_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_v_r),
    .ctl_in    (s1_ctl_r),
    .col_top   (above2),
    .col_mid   (above),
    .col_bot   (s1_ctl_r.pix),
    .krow_top  (krow_top_r),
    .krow_mid  (krow_mid_r),
    .krow_bot  (krow_bot_r),
    .push      (push),
    .push_data (push_data),
    .busy_cnt  (filt_busy)
  );

  rgbconv_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

  // hold input while queue entries plus pixels in flight fill the queue
  assign occ      = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(filt_busy) + (QCNT_W+1)'(s1_v_r);
  assign in_ready = (occ < (QCNT_W+1)'(QDEPTH));

  `RGBCONV_ASSERT_IMPL(a_queue_room, 1'b1, occ <= (QCNT_W+1)'(QDEPTH), "result queue overrun")
  `RGBCONV_ASSERT_IMPL(a_pos_range, s1_v_r, (WREG_W'(s1_ctl_r.x) < w_eff) && (s1_ctl_r.y < h_eff), "pixel position out of frame")
  `RGBCONV_ASSERT_IMPL(a_done_last, out_valid && out_data.frame_done, out_data.run_last, "frame_done without run_last")
  `RGBCONV_ASSERT_NEXT(a_push_lat, accept && (ctl_new.has_filt || ctl_new.has_pass), ##3 push, "results not queued on time")

endmodule

// ----- tb/sv/rgbconv_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB 3x3 convolution: pixel scoreboard
// Tracks line buffers, window, position and registers of the unit, predicts
// the results of each transferred pixel and checks results in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package rgbconv_tb_pkg;

  import rgbconv_pkg::*;

  localparam int MAX_REPORTS = 50;

  class conv_scoreboard;

    logic [CFG_W-1:0]    kernel_row [3];
    logic [WREG_W-1:0]   width_reg;
    logic [HREG_W-1:0]   height_reg;
    logic [PIX_W-1:0]    row_above [MAX_WIDTH];
    logic [PIX_W-1:0]    row_above2 [MAX_WIDTH];
    logic [PIX_W-1:0]    window [9];
    int                  col;
    int                  row;
    out_t                due_pixels [$];
    int                  error_count;

    function new();
      kernel_row[0] = RST_KROW_TOP;
      kernel_row[1] = RST_KROW_MID;
      kernel_row[2] = RST_KROW_BOT;
      width_reg     = RST_WIDTH;
      height_reg    = RST_HEIGHT;
      foreach (row_above[i]) row_above[i] = '0;
      foreach (row_above2[i]) row_above2[i] = '0;
      foreach (window[i]) window[i] = '0;
      col         = 0;
      row         = 0;
      error_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KROW_TOP: kernel_row[0] = data;
        REG_KROW_MID: kernel_row[1] = data;
        REG_KROW_BOT: kernel_row[2] = data;
        REG_WIDTH:    width_reg = data[WREG_W-1:0];
        REG_HEIGHT:   height_reg = data[HREG_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending_count();
      return due_pixels.size();
    endfunction

    // one channel of the window through the kernel, truncated and clamped
    function logic [CH_W-1:0] filter_channel(int ch);
      int acc;
      int r;
      int c;
      acc = 0;
      for (r = 0; r < 3; r++) begin
        for (c = 0; c < 3; c++) begin
          acc += int'(window[r*3+c][ch*CH_W +: CH_W]) * int'($signed(kernel_row[r][c*8 +: 8]));
        end
      end
      if (acc < 0) return '0;
      acc = acc >>> COEF_FRAC_BITS;
      return (acc > 255) ? 8'hFF : CH_W'(acc);
    endfunction

    function void note_pixel(in_t px);
      int               w;
      int               h;
      int               x;
      int               y;
      int               r;
      int               n;
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] above2;
      out_t             res [2];
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(height_reg);
      if (h == 0) h = 1;
      pix = {px.blue_in, px.green_in, px.red_in};

      if (px.frame_start) begin
        col = 0;
        row = 0;
      end
      // wrap a position left beyond shrunken dimensions
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      x = col;
      y = row;

      above         = row_above[x];
      above2        = row_above2[x];
      row_above2[x] = above;
      row_above[x]  = pix;
      for (r = 0; r < 3; r++) begin
        window[r*3]   = window[r*3+1];
        window[r*3+1] = window[r*3+2];
      end
      window[2] = above2;
      window[5] = above;
      window[8] = pix;

      n = 0;
      if (x >= 2 && y >= 2) begin
        res[n]           = '0;
        res[n].pos_x     = POSX_W'(x - 1);
        res[n].pos_y     = ROW_W'(y - 1);
        res[n].red_out   = filter_channel(0);
        res[n].green_out = filter_channel(1);
        res[n].blue_out  = filter_channel(2);
        n++;
      end
      if (x == 0 || y == 0 || x == w - 1 || y == h - 1) begin
        res[n]           = '0;
        res[n].pos_x     = POSX_W'(x);
        res[n].pos_y     = ROW_W'(y);
        res[n].red_out   = px.red_in;
        res[n].green_out = px.green_in;
        res[n].blue_out  = px.blue_in;
        n++;
      end
      if (n > 0) begin
        res[n-1].run_last = 1'b1;
        if (x == w - 1 && y == h - 1) res[n-1].frame_done = 1'b1;
      end
      for (r = 0; r < n; r++) due_pixels.push_back(res[r]);

      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    task report(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("[%0t] ERROR %s", $time, what);
    endtask

    task compare_field(string at, string field, logic [ROW_W-1:0] got,
                       logic [ROW_W-1:0] want);
      if (got !== want) report($sformatf("%s %s: got %0h, want %0h", at, field, got, want));
    endtask

    task check_result(out_t got);
      out_t  want;
      string at;
      if (due_pixels.size() == 0) begin
        report($sformatf("unexpected result at (%0d,%0d)", got.pos_x, got.pos_y));
        return;
      end
      want = due_pixels.pop_front();
      at   = $sformatf("pixel (%0d,%0d)", want.pos_x, want.pos_y);
      compare_field(at, "pos_x", ROW_W'(got.pos_x), ROW_W'(want.pos_x));
      compare_field(at, "pos_y", got.pos_y, want.pos_y);
      compare_field(at, "red_out", ROW_W'(got.red_out), ROW_W'(want.red_out));
      compare_field(at, "green_out", ROW_W'(got.green_out), ROW_W'(want.green_out));
      compare_field(at, "blue_out", ROW_W'(got.blue_out), ROW_W'(want.blue_out));
      compare_field(at, "run_last", ROW_W'(got.run_last), ROW_W'(want.run_last));
      compare_field(at, "frame_done", ROW_W'(got.frame_done), ROW_W'(want.frame_done));
    endtask

    task check_leftover();
      out_t want;
      while (due_pixels.size() > 0) begin
        want = due_pixels.pop_front();
        report($sformatf("missing result for pixel (%0d,%0d)", want.pos_x, want.pos_y));
      end
    endtask

  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// RGB 3x3 convolution unit testbench
// Streams RGB frames of many sizes and kernels through the unit under random
// handshake gaps and a long output stall, and checks every result pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  import rgbconv_pkg::*;
  import rgbconv_tb_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 1380;
  localparam int QUIET_TAIL    = 200;

  localparam logic [CFG_IDX_W-1:0] KROW_REGS [3] = '{REG_KROW_TOP, REG_KROW_MID,
                                                     REG_KROW_BOT};

  typedef enum int {PIX_RANDOM, PIX_EXTREME} pix_style_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  conv_scoreboard sb = new();
  bit             idle_on = 1'b1;
  bit             hold_off_req = 1'b0;
  int             cur_w;
  int             cur_h;

  rgb_convolution_3x3_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rgb_convolution_3x3_unit regression: fail");
    $finish;
  end

  // result side: check each transfer, then pick the next ready value
  initial begin : result_sink
    int gap;
    int hold;
    gap  = 0;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold         = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input in_t px);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px);
  endtask

  task automatic send_pixels(input int count, input bit start_first, input pix_style_t style,
                             input int start_pct);
    in_t px;
    for (int i = 0; i < count; i++) begin
      px.frame_start = (i == 0) ? start_first : ($urandom_range(0, 99) < start_pct);
      if (style == PIX_EXTREME) begin
        px.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        px.red_in   = CH_W'($urandom);
        px.green_in = CH_W'($urandom);
        px.blue_in  = CH_W'($urandom);
      end
      send_pixel(px);
    end
  endtask

  // stop offering, wait for every due result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_width(input int value);
    write_reg(REG_WIDTH, CFG_W'(value));
    cur_w = value % 4096;
    if (cur_w == 0) cur_w = 1;
    if (cur_w > MAX_WIDTH) cur_w = MAX_WIDTH;
  endtask

  task automatic set_height(input int value);
    write_reg(REG_HEIGHT, CFG_W'(value));
    cur_h = (value == 0) ? 1 : value;
  endtask

  initial begin : stimulus
    int         rand_items;
    int         phase;
    int         count;
    int         k;
    bit         start;
    pix_style_t style;
    rand_items = 0;
    phase      = 0;
    cur_w      = 640;
    cur_h      = 480;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset kernel is the identity: one interior pixel passes unchanged
    set_width(3);
    set_height(3);
    send_pixels(9, 1'b1, PIX_RANDOM, 0);
    drain();

    // extreme coefficients on black/white pixels: clamp and saturate
    write_reg(REG_KROW_TOP, 24'h01807F);
    write_reg(REG_KROW_MID, 24'h801010);
    write_reg(REG_KROW_BOT, 24'h7FFF00);
    set_width(4);
    set_height(4);
    send_pixels(16, 1'b1, PIX_EXTREME, 0);
    drain();

    // zero width and height act as a single-pixel frame
    set_width(0);
    set_height(0);
    send_pixels(3, 1'b1, PIX_RANDOM, 0);
    drain();

    // oversized width acts as the full line: the start of a one-row frame
    set_width(4095);
    set_height(1);
    send_pixels(40, 1'b1, PIX_RANDOM, 0);
    drain();

    set_width(MAX_WIDTH);
    set_height(65535);
    send_pixels(40, 1'b1, PIX_EXTREME, 0);
    drain();

    // shrink width, then height, in the middle of a frame
    set_width(8);
    set_height(6);
    send_pixels(29, 1'b1, PIX_RANDOM, 0);
    drain();
    set_width(3);
    send_pixels(13, 1'b0, PIX_RANDOM, 0);
    drain();
    set_height(2);
    send_pixels(6, 1'b0, PIX_RANDOM, 0);
    drain();

    while (rand_items < ITEM_TARGET) begin
      if (rand_items > ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
      for (k = 0; k < 3; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 5))
            0: write_reg(KROW_REGS[k], 24'h7F7F7F);
            1: write_reg(KROW_REGS[k], 24'h808080);
            2: write_reg(KROW_REGS[k], 24'h000000);
            3: write_reg(KROW_REGS[k], 24'h001000);
            default: write_reg(KROW_REGS[k], CFG_W'($urandom));
          endcase
        end
      end
      // a new width needs a fresh frame so the line buffers refill
      start = ($urandom_range(0, 3) != 0);
      if (phase == 0 || $urandom_range(0, 1) == 0) begin
        set_width(($urandom_range(0, 9) == 0) ? 2 : $urandom_range(1, 12));
        start = 1'b1;
      end
      if ($urandom_range(0, 1) == 0) set_height($urandom_range(0, 8));

      count = cur_w * cur_h * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, cur_w * cur_h);
      if (phase == 4) begin
        // hold the output off long enough to back up the input
        hold_off_req = 1'b1;
        if (count < 100) count = 100;
      end
      style = ($urandom_range(0, 4) == 0) ? PIX_EXTREME : PIX_RANDOM;
      send_pixels(count, start, style, ($urandom_range(0, 4) == 0) ? 3 : 0);
      rand_items += count;
      phase++;
      drain();
    end

    sb.check_leftover();
    if (sb.error_count == 0) begin
      $display("rgb_convolution_3x3_unit regression: pass");
    end else begin
      $display("rgb_convolution_3x3_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- rgb_convolution_3x3_unit.f -----
+incdir+design
design/rgbconv_pkg.sv
design/rgbconv_ram.sv
design/rgbconv_filter.sv
design/rgbconv_outq.sv
design/rgb_convolution_3x3_unit.sv
tb/sv/rgbconv_tb_pkg.sv
tb/sv/tb_top.sv
